FILE: hw/rtl/assert_macros.svh
// assertion macros included by heading_kalman_filter.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HKF_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define HKF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define HKF_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define HKF_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: hw/rtl/hkf_pkg.sv
// types, constants and microprogram of the heading kalman filter
package hkf_pkg;

	localparam int HKF_FRAC_BITS   = 16;
	localparam int HKF_VALUE_WIDTH = 32;
	localparam int WIDE_W          = 64;
	localparam int MAG_W           = 63;
	localparam int UPC_W           = 6;

	localparam logic signed [WIDE_W-1:0] WMAX_S = 64'sh3FFF_FFFF_FFFF_FFFF;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_INIT   = 1'b1;

	localparam logic [2:0] CFG_INIT_HEADING = 3'd0;
	localparam logic [2:0] CFG_INIT_COV     = 3'd1;
	localparam logic [2:0] CFG_MEAS_HEADING = 3'd2;
	localparam logic [2:0] CFG_MEAS_RATE    = 3'd3;
	localparam logic [2:0] CFG_PROC_HEADING = 3'd4;
	localparam logic [2:0] CFG_PROC_RATE    = 3'd5;

	typedef enum logic [1:0] {
		U_MAC = 2'd0,
		U_DIV = 2'd1,
		U_MOD = 2'd2,
		U_END = 2'd3
	} ukind_t;

	typedef enum logic [5:0] {
		S_ZERO, S_ACC, S_ACCN, S_DT, S_HS, S_RS,
		S_C0, S_C1, S_C2, S_C3, S_M0, S_M1, S_P0, S_P2, S_P3,
		S_QH, S_QR, S_RH, S_RR,
		S_S0, S_S1, S_S2, S_S3, S_NS1, S_NS2,
		S_B0, S_B1, S_B2, S_B3, S_K0, S_K1, S_K2, S_K3,
		S_E0, S_E1, S_T0, S_T1, S_T2, S_T3, S_HP
	} src_t;

	typedef enum logic [4:0] {
		D_NONE, D_HP, D_RP, D_M0, D_M1, D_P0, D_P2, D_P3, D_S0, D_S3, D_DET,
		D_K0, D_K1, D_K2, D_K3, D_CV0, D_CV1, D_CV2, D_CV3
	} dst_t;

	typedef struct packed {
		ukind_t kind;
		src_t   a;
		src_t   b;
		src_t   add;
		logic   neg;
		logic   mul;
		dst_t   dst;
	} uop_t;

	typedef struct packed {
		logic start;
		logic scale;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic ovf;
	} div_sts_t;

	localparam logic [UPC_W-1:0] UPC_LAST = 6'd38;

	function automatic uop_t mac(input src_t a, input src_t b, input src_t add,
			input logic neg, input logic mul, input dst_t dst);
		uop_t u;
		u = '{kind: U_MAC, a: a, b: b, add: add, neg: neg, mul: mul, dst: dst};
		return u;
	endfunction

	function automatic uop_t hkf_uop(input logic [UPC_W-1:0] pc);
		uop_t u;
		u = '{kind: U_END, a: S_ZERO, b: S_ZERO, add: S_ZERO, neg: 1'b0, mul: 1'b0,
			dst: D_NONE};
		case (pc)
			// predict
			6'd0: u = mac(S_DT, S_RS, S_HS, 1'b0, 1'b1, D_HP);
			6'd1: u = mac(S_DT, S_C2, S_C0, 1'b0, 1'b1, D_M0);
			6'd2: u = mac(S_DT, S_C3, S_C1, 1'b0, 1'b1, D_M1);
			6'd3: u = mac(S_M1, S_DT, S_M0, 1'b0, 1'b1, D_P0);
			6'd4: u = mac(S_C3, S_DT, S_C2, 1'b0, 1'b1, D_P2);
			6'd5: u = mac(S_ZERO, S_QH, S_P0, 1'b0, 1'b0, D_P0);
			6'd6: u = mac(S_ZERO, S_QR, S_C3, 1'b0, 1'b0, D_P3);
			// innovation covariance and determinant
			6'd7: u = mac(S_ZERO, S_RH, S_B0, 1'b0, 1'b0, D_S0);
			6'd8: u = mac(S_ZERO, S_RR, S_B3, 1'b0, 1'b0, D_S3);
			6'd9: u = mac(S_S0, S_S3, S_ZERO, 1'b0, 1'b1, D_DET);
			6'd10: u = mac(S_S1, S_S2, S_ACC, 1'b1, 1'b1, D_DET);
			// gain
			6'd11: u = mac(S_B0, S_S3, S_ZERO, 1'b0, 1'b1, D_NONE);
			6'd12: u = mac(S_B1, S_NS2, S_ACC, 1'b0, 1'b1, D_NONE);
			6'd13: begin
				u.kind = U_DIV;
				u.dst = D_K0;
			end
			6'd14: u = mac(S_B0, S_NS1, S_ZERO, 1'b0, 1'b1, D_NONE);
			6'd15: u = mac(S_B1, S_S0, S_ACC, 1'b0, 1'b1, D_NONE);
			6'd16: begin
				u.kind = U_DIV;
				u.dst = D_K1;
			end
			6'd17: u = mac(S_B2, S_S3, S_ZERO, 1'b0, 1'b1, D_NONE);
			6'd18: u = mac(S_B3, S_NS2, S_ACC, 1'b0, 1'b1, D_NONE);
			6'd19: begin
				u.kind = U_DIV;
				u.dst = D_K2;
			end
			6'd20: u = mac(S_B2, S_NS1, S_ZERO, 1'b0, 1'b1, D_NONE);
			6'd21: u = mac(S_B3, S_S0, S_ACC, 1'b0, 1'b1, D_NONE);
			6'd22: begin
				u.kind = U_DIV;
				u.dst = D_K3;
			end
			// correction, rate first so the heading innovation still sees the prediction
			6'd23: u = mac(S_K2, S_E0, S_ZERO, 1'b0, 1'b1, D_NONE);
			6'd24: u = mac(S_K3, S_E1, S_ACC, 1'b0, 1'b1, D_NONE);
			6'd25: u = mac(S_ZERO, S_ACCN, S_RS, 1'b0, 1'b0, D_RP);
			6'd26: u = mac(S_K0, S_E0, S_ZERO, 1'b0, 1'b1, D_NONE);
			6'd27: u = mac(S_K1, S_E1, S_ACC, 1'b0, 1'b1, D_NONE);
			6'd28: u = mac(S_ZERO, S_ACCN, S_HP, 1'b0, 1'b0, D_HP);
			6'd29: u.kind = U_MOD;
			// covariance update
			6'd30: u = mac(S_T0, S_P0, S_ZERO, 1'b0, 1'b1, D_NONE);
			6'd31: u = mac(S_T1, S_P2, S_ACC, 1'b0, 1'b1, D_CV0);
			6'd32: u = mac(S_T0, S_M1, S_ZERO, 1'b0, 1'b1, D_NONE);
			6'd33: u = mac(S_T1, S_P3, S_ACC, 1'b0, 1'b1, D_CV1);
			6'd34: u = mac(S_T2, S_P0, S_ZERO, 1'b0, 1'b1, D_NONE);
			6'd35: u = mac(S_T3, S_P2, S_ACC, 1'b0, 1'b1, D_CV2);
			6'd36: u = mac(S_T2, S_M1, S_ZERO, 1'b0, 1'b1, D_NONE);
			6'd37: u = mac(S_T3, S_P3, S_ACC, 1'b0, 1'b1, D_CV3);
			default: u.kind = U_END;
		endcase
		return u;
	endfunction

endpackage

FILE: hw/rtl/hkf_divider.sv
// restoring divider, one quotient bit per cycle, optional fraction scaling
module hkf_divider import hkf_pkg::*; #(
	parameter int VALUE_WIDTH = HKF_VALUE_WIDTH,
	parameter int FRAC_BITS   = HKF_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  div_req_t               req,
	input  logic [MAG_W-1:0]       dividend,
	input  logic [MAG_W-1:0]       divisor,
	output div_sts_t               sts,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [VALUE_WIDTH-1:0] remainder
);

	localparam int DW = WIDE_W + VALUE_WIDTH;
	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic [DW-1:0]          rem_q, dsh_q, num_init, dtop;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q, done_q, ovf_q, ge;

	always_comb begin
		num_init = req.scale ? (DW'(dividend) << FRAC_BITS) : DW'(dividend);
		dtop = DW'(divisor) << VALUE_WIDTH;
		ge = rem_q >= dsh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(VALUE_WIDTH);
				ovf_q <= num_init >= dtop;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= num_init;
			dsh_q <= DW'(divisor) << (VALUE_WIDTH - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign sts = '{busy: busy_q, done: done_q, ovf: ovf_q};
	assign quotient = quo_q;
	assign remainder = rem_q[VALUE_WIDTH-1:0];

endmodule

FILE: hw/rtl/heading_kalman_filter.sv
// two-state heading kalman filter, sequenced around one multiplier and one divider
// update beat: 33 mac steps and five divider runs, four gain divisions and one heading wrap
// zero determinant skips the four gain divisions; an init beat runs no microprogram
// one beat in flight, next beat taken the cycle after the result loads
// a result held at the output stalls only the end of the following beat
// reset: heading and rate zero, covariance diag(1000), registers at their defaults
module heading_kalman_filter import hkf_pkg::*; #(
	parameter int FRAC_BITS   = HKF_FRAC_BITS,
	parameter int VALUE_WIDTH = HKF_VALUE_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [18:0]        time_step,
	input  logic [24:0]        gps_heading,
	input  logic               gps_valid,
	input  logic signed [27:0] gyro_rate,
	input  logic               gyro_valid,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [24:0]        heading_estimate,
	output logic signed [31:0] rate_estimate,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	`include "assert_macros.svh"

	localparam int W  = VALUE_WIDTH;
	localparam int MW = W + 1;
	localparam int PW = (2 * MW > WIDE_W) ? 2 * MW : WIDE_W;

	localparam logic signed [WIDE_W-1:0] VMAX_W = (64'sd1 <<< (W - 1)) - 64'sd1;
	localparam logic signed [WIDE_W-1:0] VMIN_W = -(64'sd1 <<< (W - 1));
	localparam logic signed [WIDE_W-1:0] ONE_W  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [WIDE_W-1:0] FULL_W = 64'sd360 <<< FRAC_BITS;

	localparam logic [30:0] RST_COV = 31'((64'd1000 << FRAC_BITS) & 64'h7FFF_FFFF);
	localparam logic [30:0] RST_MNH = 31'((64'd100 << FRAC_BITS) & 64'h7FFF_FFFF);
	localparam logic [30:0] RST_MNR = 31'((64'd3 << FRAC_BITS) / 64'd100);
	localparam logic [30:0] RST_PNH = 31'((64'd100 << FRAC_BITS) & 64'h7FFF_FFFF);
	localparam logic [30:0] RST_PNR = 31'((64'd1 << FRAC_BITS) / 64'd100);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	function automatic logic signed [W-1:0] narrow(input logic signed [WIDE_W-1:0] v);
		if (v > VMAX_W) begin
			return VMAX_W[W-1:0];
		end
		if (v < VMIN_W) begin
			return VMIN_W[W-1:0];
		end
		return v[W-1:0];
	endfunction

	function automatic logic signed [WIDE_W-1:0] addw(input logic signed [WIDE_W-1:0] a,
			input logic signed [WIDE_W-1:0] b);
		logic signed [WIDE_W:0] s;
		s = (WIDE_W + 1)'(a) + (WIDE_W + 1)'(b);
		if (s > (WIDE_W + 1)'(WMAX_S)) begin
			return WMAX_S;
		end
		if (s < -(WIDE_W + 1)'(WMAX_S)) begin
			return -WMAX_S;
		end
		return s[WIDE_W-1:0];
	endfunction

	function automatic logic signed [WIDE_W-1:0] mulw(input logic signed [MW-1:0] a,
			input logic signed [MW-1:0] b);
		logic [MW-1:0]     ua, ub;
		logic [PW-1:0]     pr;
		logic [WIDE_W-1:0] q;
		logic              neg;
		ua = a[MW-1] ? MW'(-a) : MW'(a);
		ub = b[MW-1] ? MW'(-b) : MW'(b);
		neg = a[MW-1] != b[MW-1];
		pr = (PW'(ua) * PW'(ub)) >> FRAC_BITS;
		if (pr > PW'(WMAX_S)) begin
			q = WMAX_S;
		end else begin
			q = pr[WIDE_W-1:0];
		end
		return neg ? -signed'(q) : signed'(q);
	endfunction

	function automatic logic [MAG_W-1:0] magn(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] m;
		m = (v < 0) ? -v : v;
		return m[MAG_W-1:0];
	endfunction

	state_t                   state_q;
	logic [UPC_W-1:0]         pc_q;
	logic                     ph_q;
	logic                     out_valid_q;
	logic [24:0]              hout_q;
	logic signed [31:0]       rout_q;

	logic [24:0]              init_heading_q;
	logic [30:0]              init_cov_q, mnh_q, mnr_q, pnh_q, pnr_q;

	logic signed [W-1:0]      heading_q, rate_q, hp_q, rp_q;
	logic signed [W-1:0]      cov_q [4];
	logic signed [W-1:0]      k_q [4];
	logic signed [W-1:0]      m0_q, m1_q, p0_q, p2_q, p3_q, s0_q, s3_q;
	logic signed [WIDE_W-1:0] acc_q, det_q, prod_q;
	logic [18:0]              dt_q;
	logic [24:0]              zh_q;
	logic signed [27:0]       zr_q;
	logic                     g_q, y_q;

	uop_t                     uop;
	logic                     in_acc, out_free, det_zero;
	logic signed [W-1:0]      s1_w, s2_w, e0_w, e1_w, t0_w, t1_w, t2_w, t3_w;
	logic signed [W-1:0]      kv, res_n;
	logic signed [WIDE_W-1:0] add_w, res_w, rem_w, hmod_w, head64, rate64;
	logic                     qneg, qsat;
	div_req_t                 div_req;
	div_sts_t                 div_sts;
	logic [MAG_W-1:0]         div_num, div_den;
	logic [W-1:0]             quotient, remainder;

	function automatic logic signed [MW-1:0] srcv(input src_t s);
		case (s)
			S_ZERO: return '0;
			S_ACCN: return MW'(narrow(acc_q));
			S_DT:   return MW'(signed'({1'b0, dt_q}));
			S_HS:   return MW'(heading_q);
			S_RS:   return MW'(rate_q);
			S_C0:   return MW'(cov_q[0]);
			S_C1:   return MW'(cov_q[1]);
			S_C2:   return MW'(cov_q[2]);
			S_C3:   return MW'(cov_q[3]);
			S_M0:   return MW'(m0_q);
			S_M1:   return MW'(m1_q);
			S_P0:   return MW'(p0_q);
			S_P2:   return MW'(p2_q);
			S_P3:   return MW'(p3_q);
			S_QH:   return MW'(narrow(64'(signed'({1'b0, pnh_q}))));
			S_QR:   return MW'(narrow(64'(signed'({1'b0, pnr_q}))));
			S_RH:   return MW'(narrow(64'(signed'({1'b0, mnh_q}))));
			S_RR:   return MW'(narrow(64'(signed'({1'b0, mnr_q}))));
			S_S0:   return MW'(s0_q);
			S_S1:   return MW'(s1_w);
			S_S2:   return MW'(s2_w);
			S_S3:   return MW'(s3_q);
			S_NS1:  return -MW'(s1_w);
			S_NS2:  return -MW'(s2_w);
			S_B0:   return g_q ? MW'(p0_q) : '0;
			S_B1:   return y_q ? MW'(m1_q) : '0;
			S_B2:   return g_q ? MW'(p2_q) : '0;
			S_B3:   return y_q ? MW'(p3_q) : '0;
			S_K0:   return MW'(k_q[0]);
			S_K1:   return MW'(k_q[1]);
			S_K2:   return MW'(k_q[2]);
			S_K3:   return MW'(k_q[3]);
			S_E0:   return MW'(e0_w);
			S_E1:   return MW'(e1_w);
			S_T0:   return MW'(t0_w);
			S_T1:   return MW'(t1_w);
			S_T2:   return MW'(t2_w);
			S_T3:   return MW'(t3_w);
			S_HP:   return MW'(hp_q);
			default: return '0;
		endcase
	endfunction

	always_comb begin
		uop = hkf_uop(pc_q);
		in_acc = in_valid && (state_q == ST_IDLE);
		out_free = !out_valid_q || !out_stall;
		det_zero = det_q == '0;
		s1_w = (g_q && y_q) ? m1_q : '0;
		s2_w = (g_q && y_q) ? p2_q : '0;
		e0_w = g_q ? narrow(64'(signed'({1'b0, zh_q})) - 64'(hp_q)) : '0;
		e1_w = y_q ? narrow(64'(zr_q) - 64'(rate_q)) : '0;
		t0_w = narrow(ONE_W - (g_q ? 64'(k_q[0]) : 64'sd0));
		t1_w = y_q ? narrow(-64'(k_q[1])) : '0;
		t2_w = g_q ? narrow(-64'(k_q[2])) : '0;
		t3_w = narrow(ONE_W - (y_q ? 64'(k_q[3]) : 64'sd0));
		if (uop.add == S_ACC) begin
			add_w = acc_q;
		end else begin
			add_w = 64'(srcv(uop.add));
		end
		res_w = addw(add_w, uop.neg ? -prod_q : prod_q);
		res_n = narrow(res_w);
		qneg = acc_q[WIDE_W-1] != det_q[WIDE_W-1];
		qsat = div_sts.ovf || quotient[W-1];
		if (qsat) begin
			kv = qneg ? VMIN_W[W-1:0] : VMAX_W[W-1:0];
		end else begin
			kv = qneg ? -signed'(quotient) : signed'(quotient);
		end
		rem_w = 64'(signed'({1'b0, remainder}));
		hmod_w = (hp_q < 0 && remainder != '0) ? FULL_W - rem_w : rem_w;
		div_req.start = (state_q == ST_RUN) &&
			((uop.kind == U_DIV && !det_zero) || uop.kind == U_MOD);
		div_req.scale = uop.kind == U_DIV;
		div_num = (uop.kind == U_MOD) ? magn(64'(hp_q)) : magn(acc_q);
		div_den = (uop.kind == U_MOD) ? FULL_W[MAG_W-1:0] : magn(det_q);
		head64 = 64'(heading_q);
		rate64 = 64'(rate_q);
	end

	hkf_divider #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.dividend(div_num),
		.divisor(div_den),
		.sts(div_sts),
		.quotient(quotient),
		.remainder(remainder)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_heading_q <= '0;
			init_cov_q <= RST_COV;
			mnh_q <= RST_MNH;
			mnr_q <= RST_MNR;
			pnh_q <= RST_PNH;
			pnr_q <= RST_PNR;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INIT_HEADING: init_heading_q <= cfg_data[24:0];
				CFG_INIT_COV:     init_cov_q <= cfg_data;
				CFG_MEAS_HEADING: mnh_q <= cfg_data;
				CFG_MEAS_RATE:    mnr_q <= cfg_data;
				CFG_PROC_HEADING: pnh_q <= cfg_data;
				CFG_PROC_RATE:    pnr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			ph_q <= 1'b0;
			out_valid_q <= 1'b0;
			heading_q <= '0;
			rate_q <= '0;
			cov_q[0] <= narrow(64'(signed'({1'b0, RST_COV})));
			cov_q[1] <= '0;
			cov_q[2] <= '0;
			cov_q[3] <= narrow(64'(signed'({1'b0, RST_COV})));
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pc_q <= '0;
						ph_q <= 1'b0;
						if (opcode == OP_INIT) begin
							heading_q <= narrow(64'(signed'({1'b0, init_heading_q})));
							rate_q <= '0;
							cov_q[0] <= narrow(64'(signed'({1'b0, init_cov_q})));
							cov_q[1] <= '0;
							cov_q[2] <= '0;
							cov_q[3] <= narrow(64'(signed'({1'b0, init_cov_q})));
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					case (uop.kind)
						U_MAC: begin
							ph_q <= !ph_q;
							if (ph_q) begin
								pc_q <= pc_q + UPC_W'(1);
								case (uop.dst)
									D_CV0: cov_q[0] <= res_n;
									D_CV1: cov_q[1] <= res_n;
									D_CV2: cov_q[2] <= res_n;
									D_CV3: cov_q[3] <= res_n;
									default: ;
								endcase
							end
						end
						U_DIV: begin
							if (det_zero) begin
								pc_q <= pc_q + UPC_W'(1);
							end else begin
								state_q <= ST_WAIT;
							end
						end
						U_MOD: state_q <= ST_WAIT;
						default: begin
							rate_q <= rp_q;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_WAIT: begin
					if (div_sts.done) begin
						pc_q <= pc_q + UPC_W'(1);
						state_q <= ST_RUN;
						if (uop.kind == U_MOD) begin
							heading_q <= narrow(hmod_w);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers of one update
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dt_q <= time_step;
			zh_q <= gps_heading;
			g_q <= gps_valid;
			zr_q <= gyro_rate;
			y_q <= gyro_valid;
		end
		if (state_q == ST_RUN && uop.kind == U_MAC) begin
			if (!ph_q) begin
				prod_q <= uop.mul ? mulw(srcv(uop.a), srcv(uop.b)) : 64'(srcv(uop.b));
			end else begin
				acc_q <= res_w;
				case (uop.dst)
					D_HP:  hp_q <= res_n;
					D_RP:  rp_q <= res_n;
					D_M0:  m0_q <= res_n;
					D_M1:  m1_q <= res_n;
					D_P0:  p0_q <= res_n;
					D_P2:  p2_q <= res_n;
					D_P3:  p3_q <= res_n;
					D_S0:  s0_q <= res_n;
					D_S3:  s3_q <= res_n;
					D_DET: det_q <= res_w;
					default: ;
				endcase
			end
		end
		if ((state_q == ST_RUN && uop.kind == U_DIV && det_zero) ||
				(state_q == ST_WAIT && div_sts.done && uop.kind == U_DIV)) begin
			case (uop.dst)
				D_K0: k_q[0] <= det_zero ? '0 : kv;
				D_K1: k_q[1] <= det_zero ? '0 : kv;
				D_K2: k_q[2] <= det_zero ? '0 : kv;
				D_K3: k_q[3] <= det_zero ? '0 : kv;
				default: ;
			endcase
		end
		if (state_q == ST_DONE && out_free) begin
			hout_q <= head64[24:0];
			rout_q <= rate64[31:0];
		end
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign heading_estimate = hout_q;
	assign rate_estimate = rout_q;

	`HKF_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, state_q != ST_IDLE)
	`HKF_ASSERT_IMPL(a_div_done_wait, clk, arst_n, div_sts.done, state_q == ST_WAIT)
	`HKF_ASSERT_IMPL(a_pc_range, clk, arst_n, state_q == ST_RUN, pc_q <= UPC_LAST)
	`HKF_ASSERT_NEXT(a_out_load, clk, arst_n, state_q == ST_DONE && out_free, out_valid)

endmodule
